/* src/apjs_pkg.sv */
// Package for the aging priority job scheduler: types, codes and defaults.
`timescale 1ns / 1ps
package apjs_pkg;

  localparam int QueueDepthDef = 16;
  localparam int IdBitsDef     = 16;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ENQ    = 2'd1;
  localparam logic [1:0] OP_DEQ    = 2'd2;
  localparam logic [1:0] OP_FINISH = 2'd3;

  localparam logic [1:0] REG_AGE  = 2'd0;
  localparam logic [1:0] REG_CEIL = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_OPER,
    ST_PICK,
    ST_SWAP,
    ST_OUT
  } apjs_state_t;

  typedef struct packed {
    logic load;
    logic age;
    logic oper;
    logic pick;
    logic swap;
    logic finish;
  } apjs_cmd_t;

endpackage

/* src/apjs_datapath.sv */
// Datapath: wait table, running slot, aging, enqueue, dequeue and selection.
`timescale 1ns / 1ps
module apjs_datapath import apjs_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int ID_BITS     = IdBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  apjs_cmd_t   cmd,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_base_priority,
  input  logic [15:0] in_target_id,
  input  logic [7:0]  age_ticks,
  input  logic [1:0]  priority_ceiling,
  output logic        out_running_valid,
  output logic [15:0] out_running_id,
  output logic [31:0] out_running_time,
  output logic [15:0] out_assigned_id,
  output logic        out_enqueue_ok,
  output logic        out_dequeue_hit,
  output logic [4:0]  out_waiting_count,
  output logic        out_switched
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [ID_BITS-1:0] sid_r   [QUEUE_DEPTH];
  logic [1:0]         sbase_r [QUEUE_DEPTH];
  logic [1:0]         scur_r  [QUEUE_DEPTH];
  logic [7:0]         swait_r [QUEUE_DEPTH];
  logic [31:0]        srt_r   [QUEUE_DEPTH];
  logic [CW-1:0]      cnt_r;

  logic               rv_r, rd_r;
  logic [ID_BITS-1:0] rid_r, idc_r;
  logic [1:0]         rbase_r;
  logic [31:0]        rt_r;
  logic [1:0]         op_r, bpri_r;
  logic [15:0]        tgt_r;
  logic [15:0]        asg_r;
  logic               enq_r, hit_r, sw_r, fnd_r;
  logic [IW-1:0]      best_r;

  // Hit search and priority search over the cells.
  logic          found;
  logic [IW-1:0] fpos;
  logic [IW-1:0] bpos;
  logic [1:0]    bpri;
  logic [ID_BITS-1:0] nid;
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    bpos  = '0;
    bpri  = scur_r[0];
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!found && (CW'(i) < cnt_r) &&
          (ID_BITS'(in_target_id) == sid_r[i])) begin
        found = 1'b1;
        fpos  = IW'(i);
      end
      if ((CW'(i) < cnt_r) && (scur_r[i] > bpri)) begin
        bpri = scur_r[i];
        bpos = IW'(i);
      end
    end
    nid = idc_r + 1'b1;
    if (nid == '0) nid = ID_BITS'(1);
  end

  logic run_hit;
  assign run_hit = rv_r && (rid_r == ID_BITS'(tgt_r));

  logic [IW-1:0] last_idx;
  assign last_idx = cnt_r[IW-1:0] - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rv_r <= 1'b0; rd_r <= 1'b0; rid_r <= '0; idc_r <= '0;
      rbase_r <= '0; rt_r <= '0;
      op_r <= OP_TICK; bpri_r <= '0; tgt_r <= '0; asg_r <= '0;
      enq_r <= 1'b0; hit_r <= 1'b0; sw_r <= 1'b0; fnd_r <= 1'b0; best_r <= '0;
    end else begin
      if (cmd.load) begin
        op_r <= in_op; bpri_r <= in_base_priority; tgt_r <= in_target_id;
        asg_r <= '0; enq_r <= 1'b0; sw_r <= 1'b0; hit_r <= 1'b0;
        // find the dequeue target now; aging leaves the ids in place
        best_r <= found ? fpos : IW'(QUEUE_DEPTH - 1);
        fnd_r <= found;
      end
      if (cmd.finish) begin
        if (rv_r) rd_r <= 1'b1;
      end
      if (cmd.age) begin
        if (rv_r && rt_r != 32'hFFFF_FFFF) rt_r <= rt_r + 32'd1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
          logic [7:0] w;
          w = (swait_r[i] != 8'hFF) ? swait_r[i] + 8'd1 : swait_r[i];
          if (w >= age_ticks && scur_r[i] < priority_ceiling) begin
            scur_r[i]  <= scur_r[i] + 2'd1;
            swait_r[i] <= 8'd0;
          end else begin
            swait_r[i] <= w;
          end
        end
      end
      if (cmd.oper) begin
        if (op_r == OP_ENQ) begin
          if (cnt_r < CW'(QUEUE_DEPTH)) begin
            idc_r <= nid;
            sid_r[cnt_r[IW-1:0]] <= nid;
            sbase_r[cnt_r[IW-1:0]] <= bpri_r;
            scur_r[cnt_r[IW-1:0]] <= bpri_r;
            swait_r[cnt_r[IW-1:0]] <= 8'd0;
            srt_r[cnt_r[IW-1:0]] <= 32'd0;
            cnt_r <= cnt_r + 1'b1;
            asg_r <= 16'(nid);
            enq_r <= 1'b1;
          end
        end else if (op_r == OP_DEQ) begin
          if (run_hit) begin
            rv_r <= 1'b0; rd_r <= 1'b0; rid_r <= '0;
            rbase_r <= '0; rt_r <= '0;
            hit_r <= 1'b1;
          end else if (fnd_r) begin
            for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
              if (IW'(i) >= best_r) begin
                sid_r[i] <= sid_r[i+1]; sbase_r[i] <= sbase_r[i+1];
                scur_r[i] <= scur_r[i+1]; swait_r[i] <= swait_r[i+1];
                srt_r[i] <= srt_r[i+1];
              end
            end
            cnt_r <= cnt_r - 1'b1;
            hit_r <= 1'b1;
          end
        end
      end
      if (cmd.pick) begin
        best_r <= bpos;
        if (rv_r && rd_r) begin
          rv_r <= 1'b0; rd_r <= 1'b0;
        end
      end
      if (cmd.swap && cnt_r != '0) begin
        rv_r <= 1'b1; rd_r <= 1'b0;
        rid_r <= sid_r[best_r]; rbase_r <= sbase_r[best_r];
        rt_r <= srt_r[best_r];
        sw_r <= 1'b1;
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          if (IW'(i) >= best_r && !(rv_r && IW'(i) == last_idx)) begin
            sid_r[i] <= sid_r[i+1]; sbase_r[i] <= sbase_r[i+1];
            scur_r[i] <= scur_r[i+1]; swait_r[i] <= swait_r[i+1];
            srt_r[i] <= srt_r[i+1];
          end
        end
        if (rv_r) begin
          // displaced job goes to the back at base priority
          sid_r[last_idx] <= rid_r;
          sbase_r[last_idx] <= rbase_r;
          scur_r[last_idx] <= rbase_r;
          swait_r[last_idx] <= 8'd0;
          srt_r[last_idx] <= rt_r;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  logic [CW:0] cnt_w;
  assign cnt_w = (CW+1)'(cnt_r);
  assign out_running_valid = rv_r;
  assign out_running_id    = rv_r ? 16'(rid_r) : 16'd0;
  assign out_running_time  = rv_r ? rt_r : 32'd0;
  assign out_assigned_id   = (op_r == OP_ENQ) ? asg_r : 16'd0;
  assign out_enqueue_ok    = (op_r == OP_ENQ) && enq_r;
  assign out_dequeue_hit   = hit_r;
  assign out_waiting_count = 5'(cnt_w);
  assign out_switched      = sw_r;

endmodule

/* src/apjs_ctrl.sv */
// Controller: sequences the steps of one word and holds the result.
`timescale 1ns / 1ps
module apjs_ctrl import apjs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_op,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  output apjs_cmd_t  cmd
);

  apjs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == OP_FINISH) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_OUT;
          end else begin
            state_nxt = ST_AGE;
          end
        end
      end
      ST_AGE:  begin cmd.age  = 1'b1; state_nxt = ST_OPER; end
      ST_OPER: begin cmd.oper = 1'b1; state_nxt = ST_PICK; end
      ST_PICK: begin cmd.pick = 1'b1; state_nxt = ST_SWAP; end
      ST_SWAP: begin cmd.swap = 1'b1; state_nxt = ST_OUT; end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* src/aging_priority_job_scheduler_unit.sv */
// Top level of the aging priority job scheduler.
`timescale 1ns / 1ps
// Each tick, enqueue or dequeue word runs as a short sequence: load, age
// all waiting jobs, apply any enqueue or dequeue, pick the earliest
// highest-priority job, then swap it into the running slot. A finish word
// only loads and marks the running job done. The result then waits in the
// output stage. The controller's steps drive the shared table cells.
module aging_priority_job_scheduler_unit import apjs_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int ID_BITS     = IdBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [1:0]  in_base_priority,
  input  logic [15:0] in_target_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_running_valid,
  output logic [15:0] out_running_id,
  output logic [31:0] out_running_time,
  output logic [15:0] out_assigned_id,
  output logic        out_enqueue_ok,
  output logic        out_dequeue_hit,
  output logic [4:0]  out_waiting_count,
  output logic        out_switched,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] age_r;
  logic [1:0] ceil_r;
  apjs_cmd_t  cmd;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r  <= 8'd5;
      ceil_r <= 2'd3;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_AGE[0])       age_r  <= cfg_pwdata[7:0];
      else if (cfg_paddr[2] == REG_CEIL[0]) ceil_r <= cfg_pwdata[1:0];
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_AGE[0]: cfg_prdata = {24'd0, age_r};
      default:    cfg_prdata = {30'd0, ceil_r};
    endcase
  end

  apjs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_op, .in_stall, .out_valid, .out_stall, .cmd
  );

  apjs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_dp (
    .clk, .rst_n, .cmd, .in_op, .in_base_priority, .in_target_id,
    .age_ticks(age_r), .priority_ceiling(ceil_r),
    .out_running_valid, .out_running_id, .out_running_time, .out_assigned_id,
    .out_enqueue_ok, .out_dequeue_hit, .out_waiting_count, .out_switched
  );

endmodule
